// ===== hdl/cclb_pkg.sv =====
package cclb_pkg;

  // load band codes, also reported on the result channel
  typedef enum logic [2:0] {
    BAND_NORMAL   = 3'd0,
    BAND_LOWER    = 3'd1,
    BAND_UPPER    = 3'd2,
    BAND_ALARM    = 3'd3,
    BAND_FALLBACK = 3'd4
  } band_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_RATED_LIMIT      = 3'd0,
    REG_OVERRIDE_LIMIT   = 3'd1,
    REG_FALLBACK_CURRENT = 3'd2,
    REG_ALARM_THRESHOLD  = 3'd3,
    REG_UPPER_THRESHOLD  = 3'd4,
    REG_LOWER_THRESHOLD  = 3'd5,
    REG_WAIT_SECONDS     = 3'd6,
    REG_STEP_AMOUNTS     = 3'd7
  } reg_index_t;

  // command codes of an input transaction
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // phase code that is never stored
  localparam logic [1:0] PHASE_INVALID = 2'd3;

  localparam logic [7:0]  WAIT_UNSET       = 8'hFF;
  localparam logic [7:0]  AGE_MAX          = 8'hFF;
  localparam logic [31:0] TICK_INTERVAL_MS = 32'd1000;

  // milliseconds to seconds: floor(x / 1000) == (x * SEC_RECIP) >> SEC_SHIFT for 32-bit x
  localparam int          SECS_W    = 23;
  localparam int          RECIP_W   = 29;
  localparam int          SEC_SHIFT = 38;
  localparam logic [RECIP_W-1:0] SEC_RECIP = 29'd274877907;

  typedef struct packed {
    logic [15:0] rated_limit;
    logic [15:0] override_limit;
    logic [15:0] fallback_current;
    logic [15:0] alarm_threshold;
    logic [15:0] upper_threshold;
    logic [15:0] lower_threshold;
    logic [31:0] wait_seconds;
    logic [47:0] step_amounts;
  } cfg_t;

  typedef struct packed {
    band_t              band;
    logic [7:0]         wait_count;
    logic [7:0]         sample_age;
    logic [15:0]        drive;
    logic [SECS_W-1:0]  last_check;
  } check_state_t;

endpackage

// ===== hdl/cclb_check.sv =====
module cclb_check (
  input  cclb_pkg::cfg_t            cfg,
  input  cclb_pkg::check_state_t    state,
  input  logic [15:0]               max_current,
  input  logic [cclb_pkg::SECS_W-1:0] secs,
  output cclb_pkg::check_state_t    state_next
);

  logic [cclb_pkg::SECS_W-1:0] diff;
  logic [cclb_pkg::SECS_W-1:0] wait_ext;
  logic [cclb_pkg::SECS_W-1:0] gap_ext;
  logic [7:0]                  age_gap;
  logic [7:0]                  wait_cnt;
  logic [7:0]                  age_new;
  logic [7:0]                  wait_band;
  logic [7:0]                  wait_cfg;
  logic [7:0]                  wait_new;
  logic                        act;
  cclb_pkg::band_t             band_new;
  logic signed [17:0]          drive_ext;
  logic signed [17:0]          drive_step;
  logic [15:0]                 drive_clamp;

  // elapsed seconds since the previous check, zero on the first one
  assign diff = (state.last_check == '0) ? '0 : secs - state.last_check;

  // countdown of the band wait timer
  assign wait_ext = {{(cclb_pkg::SECS_W-8){1'b0}}, state.wait_count};
  always_comb begin
    if (state.wait_count == cclb_pkg::WAIT_UNSET) begin
      wait_cnt = state.wait_count;
    end else if (state.wait_count != 8'd0 && diff < wait_ext) begin
      wait_cnt = state.wait_count - diff[7:0];
    end else begin
      wait_cnt = 8'd0;
    end
  end

  // sample aging, saturating
  assign age_gap = cclb_pkg::AGE_MAX - state.sample_age;
  assign gap_ext = {{(cclb_pkg::SECS_W-8){1'b0}}, age_gap};
  always_comb begin
    if (state.sample_age != cclb_pkg::AGE_MAX && diff < gap_ext) begin
      age_new = state.sample_age + diff[7:0];
    end else begin
      age_new = cclb_pkg::AGE_MAX;
    end
  end

  // band by priority
  always_comb begin
    if (age_new >= cfg.wait_seconds[31:24]) begin
      band_new = cclb_pkg::BAND_FALLBACK;
    end else if (max_current > cfg.alarm_threshold) begin
      band_new = cclb_pkg::BAND_ALARM;
    end else if (max_current > cfg.upper_threshold) begin
      band_new = cclb_pkg::BAND_UPPER;
    end else if (max_current <= cfg.lower_threshold) begin
      band_new = cclb_pkg::BAND_LOWER;
    end else begin
      band_new = cclb_pkg::BAND_NORMAL;
    end
  end

  assign wait_band = (band_new != state.band) ? cclb_pkg::WAIT_UNSET : wait_cnt;

  // wait handling of the selected band
  always_comb begin
    case (band_new)
      cclb_pkg::BAND_LOWER:    wait_cfg = cfg.wait_seconds[7:0];
      cclb_pkg::BAND_UPPER:    wait_cfg = cfg.wait_seconds[15:8];
      cclb_pkg::BAND_ALARM:    wait_cfg = cfg.wait_seconds[23:16];
      cclb_pkg::BAND_FALLBACK: wait_cfg = cfg.wait_seconds[31:24];
      default:                 wait_cfg = cclb_pkg::WAIT_UNSET;
    endcase
  end

  always_comb begin
    act      = 1'b0;
    wait_new = wait_band;
    if (band_new != cclb_pkg::BAND_NORMAL) begin
      if (wait_band == cclb_pkg::WAIT_UNSET) begin
        wait_new = wait_cfg;
      end else if (wait_band == 8'd0) begin
        wait_new = cclb_pkg::WAIT_UNSET;
        act      = 1'b1;
      end
    end
  end

  // drive step or fallback load
  assign drive_ext = signed'({2'b00, state.drive});
  always_comb begin
    drive_step = drive_ext;
    if (act) begin
      case (band_new)
        cclb_pkg::BAND_LOWER:
          drive_step = drive_ext + signed'({2'b00, cfg.step_amounts[15:0]});
        cclb_pkg::BAND_UPPER:
          drive_step = drive_ext - signed'({2'b00, cfg.step_amounts[31:16]});
        cclb_pkg::BAND_ALARM:
          drive_step = drive_ext - signed'({2'b00, cfg.step_amounts[47:32]});
        cclb_pkg::BAND_FALLBACK:
          drive_step = signed'({2'b00, cfg.fallback_current});
        default:
          drive_step = drive_ext;
      endcase
    end
  end

  // clamp to zero and to the charger or override ceiling
  always_comb begin
    if (drive_step[17]) begin
      drive_clamp = 16'd0;
    end else if (drive_step[16:0] > {1'b0, cfg.rated_limit}) begin
      if (drive_step[16:0] > {1'b0, cfg.override_limit}) begin
        drive_clamp = cfg.override_limit;
      end else begin
        drive_clamp = cfg.rated_limit;
      end
    end else begin
      drive_clamp = drive_step[15:0];
    end
  end

  always_comb begin
    state_next.band       = band_new;
    state_next.wait_count = wait_new;
    state_next.sample_age = age_new;
    state_next.drive      = drive_clamp;
    state_next.last_check = secs;
  end

endmodule

// ===== hdl/charger_current_load_balancer.sv =====
// Charger current load balancer.
// Input channel (in_valid/in_stall) carries one transaction per cycle unless
// stalled: cmd 0 is a grid current sample for one phase, cmd 1 is a millisecond
// time tick. A tick more than 1000 ms after the previous tick runs a check that
// ages the sample, picks a band, counts the band wait down in seconds and steps or
// resets the drive limit. Each check gives one result transaction (drive_limit,
// band) on the output channel (out_valid/out_stall); samples and short ticks give
// none. Configuration is written through cfg_write/cfg_index/cfg_data, by the user
// only while idle; the block does not enforce this. A transaction enters the input
// register, with milliseconds already turned into seconds by a reciprocal multiply;
// when the check stage advances, the check updates state and loads the output
// register. Throughput: one transaction per cycle when not stalled, set by the
// single check stage. When the receiver stalls, the held result blocks the check
// stage and in_stall rises once the input register is also full; nothing is dropped.
// Reset (rst, synchronous) clears configuration, samples, band to normal, wait timer
// to unset, sample age to its maximum, drive to zero and both timestamps to zero.
module charger_current_load_balancer #(
  parameter int NUM_PHASES = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [1:0]  phase,
  input  logic [15:0] current,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] drive_limit,
  output logic [2:0]  band
);

  cclb_pkg::cfg_t               cfg;
  cclb_pkg::check_state_t       state;
  cclb_pkg::check_state_t       state_next;
  logic [15:0]                  phase_current [NUM_PHASES];
  logic [31:0]                  last_tick_ms;
  logic [15:0]                  max_current;

  logic                         s1_valid;
  logic                         s1_cmd;
  logic [1:0]                   s1_phase;
  logic [15:0]                  s1_current;
  logic [31:0]                  s1_now;
  logic [cclb_pkg::SECS_W-1:0]  s1_secs;
  logic [cclb_pkg::SECS_W-1:0]  secs_next;
  logic [31+cclb_pkg::RECIP_W:0] sec_product;

  logic                         advance;
  logic                         fire;
  logic                         run_check;
  logic [31:0]                  tick_gap;
  cclb_pkg::band_t              band_out;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cclb_pkg::reg_index_t'(cfg_index))
        cclb_pkg::REG_RATED_LIMIT:      cfg.rated_limit      <= cfg_data[15:0];
        cclb_pkg::REG_OVERRIDE_LIMIT:   cfg.override_limit   <= cfg_data[15:0];
        cclb_pkg::REG_FALLBACK_CURRENT: cfg.fallback_current <= cfg_data[15:0];
        cclb_pkg::REG_ALARM_THRESHOLD:  cfg.alarm_threshold  <= cfg_data[15:0];
        cclb_pkg::REG_UPPER_THRESHOLD:  cfg.upper_threshold  <= cfg_data[15:0];
        cclb_pkg::REG_LOWER_THRESHOLD:  cfg.lower_threshold  <= cfg_data[15:0];
        cclb_pkg::REG_WAIT_SECONDS:     cfg.wait_seconds     <= cfg_data[31:0];
        cclb_pkg::REG_STEP_AMOUNTS:     cfg.step_amounts     <= cfg_data;
        default:                        cfg <= cfg;
      endcase
    end
  end

  // handshake: the check stage moves when the output register is free or drains
  assign advance  = !out_valid || !out_stall;
  assign fire     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  // milliseconds to seconds by reciprocal multiply
  assign sec_product = {{cclb_pkg::RECIP_W{1'b0}}, now_ms}
                     * {32'd0, cclb_pkg::SEC_RECIP};
  assign secs_next = sec_product[cclb_pkg::SEC_SHIFT+cclb_pkg::SECS_W-1:cclb_pkg::SEC_SHIFT];

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_cmd     <= cmd;
      s1_phase   <= phase;
      s1_current <= current;
      s1_now     <= now_ms;
      s1_secs    <= secs_next;
    end
  end

  // largest current over the phases in use
  always_comb begin
    max_current = 16'd0;
    for (int i = 0; i < NUM_PHASES; i++) begin
      if (phase_current[i] > max_current) begin
        max_current = phase_current[i];
      end
    end
  end

  assign tick_gap  = s1_now - last_tick_ms;
  assign run_check = fire && s1_cmd == cclb_pkg::CMD_TICK
                  && tick_gap > cclb_pkg::TICK_INTERVAL_MS;

  cclb_check u_check (
    .cfg         (cfg),
    .state       (state),
    .max_current (max_current),
    .secs        (s1_secs),
    .state_next  (state_next)
  );

  // per-phase sample storage
  for (genvar g = 0; g < NUM_PHASES; g++) begin : g_phase
    always_ff @(posedge clk) begin
      if (rst) begin
        phase_current[g] <= 16'd0;
      end else if (fire && s1_cmd == cclb_pkg::CMD_SAMPLE && s1_phase == 2'(g)) begin
        phase_current[g] <= s1_current;
      end
    end
  end

  // check state and tick time
  always_ff @(posedge clk) begin
    if (rst) begin
      state.band       <= cclb_pkg::BAND_NORMAL;
      state.wait_count <= cclb_pkg::WAIT_UNSET;
      state.sample_age <= cclb_pkg::AGE_MAX;
      state.drive      <= 16'd0;
      state.last_check <= '0;
      last_tick_ms     <= 32'd0;
    end else if (fire) begin
      if (s1_cmd == cclb_pkg::CMD_SAMPLE) begin
        if (s1_phase != cclb_pkg::PHASE_INVALID) begin
          state.sample_age <= 8'd0;
        end
      end else begin
        last_tick_ms <= s1_now;
        if (run_check) begin
          state <= state_next;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (run_check) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (run_check) begin
      drive_limit <= state_next.drive;
      band_out    <= state_next.band;
    end
  end

  assign band = band_out;

`ifndef SYNTHESIS
  // a new result only follows a tick in the check stage
  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_cmd == cclb_pkg::CMD_TICK))
    else $error("result without a tick");

  // a stored sample restarts the age
  a_sample_age: assert property (@(posedge clk) disable iff (rst)
    (fire && s1_cmd == cclb_pkg::CMD_SAMPLE && s1_phase != cclb_pkg::PHASE_INVALID)
    |=> state.sample_age == 8'd0)
    else $error("sample age not cleared");

  // input backpressure only comes from a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output stall");
`endif

endmodule
